@@ hw/rtl/smw_pkg.sv @@
// ----------------------------------------------------------------------------
// smw_pkg
// Shared types and constants of the sliding window median filter.
// ----------------------------------------------------------------------------
package smw_pkg;

  localparam int CFG_W = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_COUNT,
    ST_PICK,
    ST_SCAN,
    ST_WAIT
  } st_t;

  typedef struct packed {
    logic load;
    logic count;
    logic pick;
    logic shift;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/smw_cell.sv @@
// ----------------------------------------------------------------------------
// smw_cell
// One window slot: holds a sample, counts how many window samples lie below
// and at or below it as the window rotates past, then flags itself when its
// rank matches and hands its flag and value toward cell zero.
// ----------------------------------------------------------------------------
module smw_cell import smw_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  cell_ctrl_t                     ctrl,
  input  logic                           wr_en,
  input  logic signed [SAMPLE_WIDTH-1:0] wr_data,
  input  logic                           active,
  input  logic        [CFG_W-1:0]        rank,
  input  logic signed [SAMPLE_WIDTH-1:0] rot_in,
  input  logic                           flag_in,
  output logic signed [SAMPLE_WIDTH-1:0] rot,
  output logic                           flag
);

  logic signed [SAMPLE_WIDTH-1:0] store;
  logic        [CFG_W-1:0]        below;
  logic        [CFG_W-1:0]        upto;
  logic                           hit;

  assign hit = active && (below <= rank) && (rank < upto);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load || ctrl.pick) begin
      rot <= store;
    end else if (ctrl.count || ctrl.shift) begin
      rot <= rot_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      below <= '0;
      upto  <= '0;
    end else if (ctrl.count && active) begin
      below <= below + CFG_W'(rot < store);
      upto  <= upto + CFG_W'(rot <= store);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pick) begin
      flag <= hit;
    end else if (ctrl.shift) begin
      flag <= flag_in;
    end
  end

endmodule

@@ hw/rtl/sliding_window_median.sv @@
// ----------------------------------------------------------------------------
// sliding_window_median
// Streaming lower-median filter over the last window_size samples (clamped to
// 1..MAX_WINDOW), built as a ring of slot cells that rank every sample against the rotating window.
// ----------------------------------------------------------------------------
// Sequence: a result-producing sample is loaded into the ring, ranked by a
//   rotation through the cell ring, picked, found by a scan of up to k cell
//   flags (k = window) and held until the output is free; no new sample is
//   taken before that ends. Samples that only fill the window are taken one per cycle.
// Reset: fill count and oldest slot clear, window_size returns to 3, output
//   empty; the sample store is not cleared.
// ----------------------------------------------------------------------------
module sliding_window_median import smw_pkg::*; #(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           sample_valid,
  output logic                           sample_ready,
  output logic signed [SAMPLE_WIDTH-1:0] median,
  output logic                           median_valid,
  input  logic                           median_ready,
  input  logic        [CFG_W-1:0]        window_size,
  input  logic                           window_size_valid,
  output logic                           window_size_ready
);

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  st_t                            st;
  st_t                            st_next;
  logic        [CFG_W-1:0]        ws;
  logic        [CFG_W-1:0]        k;
  logic        [CFG_W-1:0]        rank;
  logic        [CFG_W-1:0]        fill;
  logic        [CFG_W-1:0]        fill_next;
  logic        [IDX_W-1:0]        optr;
  logic        [IDX_W-1:0]        optr_next;
  logic        [IDX_W-1:0]        wr_slot;
  logic                           produce;
  logic                           accept;
  logic        [CFG_W-1:0]        cnt;
  logic                           cnt_last;
  logic                           cnt_clr;
  logic                           cnt_inc;
  logic                           res_load;
  logic                           out_load;
  logic                           out_free;
  logic signed [SAMPLE_WIDTH-1:0] res;
  cell_ctrl_t                     ctrl;
  logic signed [SAMPLE_WIDTH-1:0] rot_w  [MAX_WINDOW];
  logic                           flag_w [MAX_WINDOW];

  assign window_size_ready = 1'b1;
  assign accept   = sample_valid && sample_ready;
  assign out_free = !median_valid || median_ready;
  assign cnt_last = (cnt == k - 1'b1);
  assign rank     = (k - 1'b1) >> 1;

  always_comb begin
    if (ws == '0) begin
      k = CFG_W'(1);
    end else if (int'(ws) > MAX_WINDOW) begin
      k = CFG_W'(MAX_WINDOW);
    end else begin
      k = ws;
    end
  end

  always_comb begin
    wr_slot   = optr;
    optr_next = optr;
    fill_next = fill;
    produce   = 1'b1;
    if (fill < k) begin
      wr_slot   = IDX_W'(fill);
      fill_next = fill + 1'b1;
      produce   = (CFG_W'(fill + 1'b1) >= k);
    end else begin
      if (int'(optr) >= int'(k)) begin
        wr_slot = '0;
      end
      if (int'(wr_slot) + 1 >= int'(k)) begin
        optr_next = '0;
      end else begin
        optr_next = wr_slot + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ws <= CFG_W'(3);
    end else if (window_size_valid && window_size_ready) begin
      ws <= window_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      optr <= '0;
    end else if (accept) begin
      fill <= fill_next;
      optr <= optr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE: begin
        if (accept && produce) st_next = ST_LOAD;
      end
      ST_LOAD:  st_next = ST_COUNT;
      ST_COUNT: begin
        if (cnt_last) st_next = ST_PICK;
      end
      ST_PICK:  st_next = ST_SCAN;
      ST_SCAN: begin
        if (flag_w[0] || cnt_last) st_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (out_free) st_next = ST_IDLE;
      end
      default:  st_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sample_ready = 1'b0;
    ctrl         = '0;
    cnt_clr      = 1'b0;
    cnt_inc      = 1'b0;
    res_load     = 1'b0;
    out_load     = 1'b0;
    unique case (st)
      ST_IDLE:  sample_ready = 1'b1;
      ST_LOAD: begin
        ctrl.load = 1'b1;
        cnt_clr   = 1'b1;
      end
      ST_COUNT: begin
        ctrl.count = 1'b1;
        cnt_inc    = 1'b1;
      end
      ST_PICK: begin
        ctrl.pick = 1'b1;
        cnt_clr   = 1'b1;
      end
      ST_SCAN: begin
        ctrl.shift = 1'b1;
        cnt_inc    = 1'b1;
        res_load   = flag_w[0] || cnt_last;
      end
      ST_WAIT:  out_load = out_free;
      default: begin
        sample_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cnt_clr) begin
      cnt <= '0;
    end else if (cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= rot_w[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      median_valid <= 1'b0;
    end else if (out_load) begin
      median_valid <= 1'b1;
    end else if (median_ready) begin
      median_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      median <= res;
    end
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] rot_in;
    logic                           flag_in;

    if (i == MAX_WINDOW - 1) begin : g_last
      assign rot_in  = rot_w[0];
      assign flag_in = 1'b0;
    end else begin : g_mid
      assign rot_in  = (i == int'(k) - 1) ? rot_w[0] : rot_w[i+1];
      assign flag_in = (i == int'(k) - 1) ? 1'b0 : flag_w[i+1];
    end

    smw_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .wr_en   (accept && (int'(wr_slot) == i)),
      .wr_data (sample),
      .active  (i < int'(k)),
      .rank    (rank),
      .rot_in  (rot_in),
      .flag_in (flag_in),
      .rot     (rot_w[i]),
      .flag    (flag_w[i])
    );
  end

endmodule

@@ hw/rtl/smw_checker.sv @@
// ----------------------------------------------------------------------------
// smw_checker
// Port-level checks of the sliding window median filter.
// ----------------------------------------------------------------------------
module smw_checker #(
  parameter int SAMPLE_WIDTH = 32
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           sample_valid,
  input logic                           sample_ready,
  input logic signed [SAMPLE_WIDTH-1:0] median,
  input logic                           median_valid,
  input logic                           median_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    median_valid && !median_ready |=> median_valid && $stable(median))
    else $error("median request dropped or changed while stalled");

  a_new_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(median_valid) |-> $past(!sample_ready))
    else $error("median request appeared without a busy period");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !median_valid)
    else $error("median request present after reset");

  a_busy_holds_out: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready && median_valid && !median_ready |=> median_valid)
    else $error("pending median lost when a sample was taken");

endmodule

bind sliding_window_median smw_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_smw_checker (.*);
